// ===== design/pcd_pkg.sv =====
`default_nettype none
package pcd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MAX_ITEMS = 65536;
    localparam int CNT_W     = 17;
    localparam int SUM_W     = 32;
    localparam int SXY_W     = 48;
    localparam int SQ_W      = 47;
    localparam int OP_W      = 64;
    localparam int PROD_W    = 128;
    localparam int NUM_W     = 80;
    localparam int Q_W       = 15;
    localparam int DIST_W    = 16;
    localparam logic [DIST_W-1:0] ONE_Q14 = 16'd16384;

    typedef struct packed {
        logic acc_en;
        logic clear;
    } acc_ctl_t;

    typedef struct packed {
        logic sqrt_start;
        logic div_start;
    } rd_ctl_t;

endpackage
`default_nettype wire

// ===== design/pcd_accum.sv =====
`default_nettype none
module pcd_accum
    import pcd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire acc_ctl_t                ctl,
    input  wire logic signed [SAMPLE_W-1:0] x_in,
    input  wire logic signed [SAMPLE_W-1:0] y_in,
    output logic [CNT_W-1:0]             count,
    output logic signed [SUM_W-1:0]      sum_x,
    output logic signed [SUM_W-1:0]      sum_y,
    output logic signed [SXY_W-1:0]      sum_xy,
    output logic [SQ_W-1:0]              sum_xx,
    output logic [SQ_W-1:0]              sum_yy
);

    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [SXY_W-1:0] sxy_reg;
    logic [SQ_W-1:0]         sxx_reg, syy_reg;
    logic signed [31:0]      pxy, pxx, pyy;
    logic                    room;

    assign pxy  = x_in * y_in;
    assign pxx  = x_in * x_in;
    assign pyy  = y_in * y_in;
    assign room = count_reg < CNT_W'(MAX_ITEMS);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
        end else if (ctl.acc_en && room) begin
            count_reg <= count_reg + CNT_W'(1);
            sx_reg    <= sx_reg + {{(SUM_W-SAMPLE_W){x_in[SAMPLE_W-1]}}, x_in};
            sy_reg    <= sy_reg + {{(SUM_W-SAMPLE_W){y_in[SAMPLE_W-1]}}, y_in};
            sxy_reg   <= sxy_reg + {{(SXY_W-32){pxy[31]}}, pxy};
            sxx_reg   <= sxx_reg + {{(SQ_W-31){1'b0}}, pxx[30:0]};
            syy_reg   <= syy_reg + {{(SQ_W-31){1'b0}}, pyy[30:0]};
        end
    end

    assign count  = count_reg;
    assign sum_x  = sx_reg;
    assign sum_y  = sy_reg;
    assign sum_xy = sxy_reg;
    assign sum_xx = sxx_reg;
    assign sum_yy = syy_reg;

endmodule
`default_nettype wire

// ===== design/pcd_mul.sv =====
`default_nettype none
module pcd_mul
    import pcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [OP_W-1:0]   op_a,
    input  wire logic [OP_W-1:0]   op_b,
    output logic [PROD_W-1:0]      product,
    output logic                   done
);

    logic [OP_W-1:0]   a_reg, b_reg;
    logic [2:0]        cnt_reg;
    logic              run_reg, pp_v_reg, done_reg;
    logic [63:0]       pp_reg;
    logic [1:0]        sh_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [31:0]       a_limb, b_limb;

    // limb order: a0b0, a0b1, a1b0, a1b1
    assign a_limb = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_limb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            pp_v_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                pp_v_reg <= 1'b0;
                cnt_reg  <= '0;
            end else if (run_reg) begin
                pp_v_reg <= ~cnt_reg[2];
                cnt_reg  <= cnt_reg + 3'd1;
                if (cnt_reg[2]) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (run_reg) begin
            pp_reg <= a_limb * b_limb;
            sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            if (pp_v_reg)
                acc_reg <= acc_reg + ({64'd0, pp_reg} << {sh_reg, 5'd0});
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule
`default_nettype wire

// ===== design/pcd_rootdiv.sv =====
`default_nettype none
module pcd_rootdiv
    import pcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rd_ctl_t           ctl,
    input  wire logic [PROD_W-1:0] radicand,
    input  wire logic [OP_W-1:0]   cov_mag,
    output logic [Q_W-1:0]         quotient,
    output logic                   done
);

    logic [PROD_W-1:0] rad_reg;
    logic [65:0]       rem_reg;
    logic [OP_W-1:0]   root_reg;
    logic [5:0]        scnt_reg;
    logic              sqrt_run_reg, div_run_reg, done_reg;
    logic [NUM_W-1:0]  num_reg, dsh_reg;
    logic [3:0]        dcnt_reg;
    logic [Q_W-1:0]    q_reg;
    logic [67:0]       rem_sh, trial;
    logic              fits;

    assign rem_sh = {rem_reg, rad_reg[PROD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = num_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqrt_run_reg <= 1'b0;
            div_run_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.sqrt_start) begin
                sqrt_run_reg <= 1'b1;
            end else if (sqrt_run_reg && scnt_reg == 6'd0) begin
                sqrt_run_reg <= 1'b0;
                done_reg     <= 1'b1;
            end
            if (ctl.div_start) begin
                div_run_reg <= 1'b1;
            end else if (div_run_reg && (dcnt_reg == 4'd0 || (dcnt_reg == 4'd14 && fits))) begin
                div_run_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sqrt_start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            scnt_reg <= 6'd63;
        end else if (sqrt_run_reg) begin
            // one root bit a step: bring down two radicand bits, try the subtraction
            rad_reg  <= rad_reg << 2;
            scnt_reg <= scnt_reg - 6'd1;
            if (rem_sh >= trial) begin
                rem_reg  <= 66'(rem_sh - trial);
                root_reg <= {root_reg[OP_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[65:0];
                root_reg <= {root_reg[OP_W-2:0], 1'b0};
            end
        end
        if (ctl.div_start) begin
            num_reg  <= {1'b0, cov_mag, 15'd0} + {16'd0, root_reg};
            dsh_reg  <= {1'b0, root_reg, 15'd0};
            dcnt_reg <= 4'd14;
            q_reg    <= '0;
        end else if (div_run_reg) begin
            // the first trial at bit 14 doubles as the saturation check
            dsh_reg  <= dsh_reg >> 1;
            dcnt_reg <= dcnt_reg - 4'd1;
            if (fits) begin
                num_reg           <= num_reg - dsh_reg;
                q_reg[dcnt_reg]   <= 1'b1;
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

// ===== design/pearson_correlation_distance.sv =====
`default_nettype none
// Pearson correlation distance over a stream of sample pairs.
// Slave channel: one transaction per pair, s_tdata = {y_sample, x_sample},
// s_tlast marks the final pair of a vector. Each pair is captured, then
// accumulated through three 16x16 multipliers; s_tready stays low until
// it is summed. Pairs beyond 65536 are dropped. On the last pair the
// sequencer runs seven 64x64 products through one shared 32x32
// multiplier, a 64-step square root and a 15-step restoring divide in
// one shift-subtract unit (four products only, when a variance term is
// zero; the divide stops at its first step when the quotient saturates).
// No pair is taken until the result moves into the output register.
// Master channel: one transaction per vector, m_tdata = {item_count,
// distance}, m_tuser = degenerate (a zero variance term; distance is 0).
// distance is 1 - r in Q2.14, rounded to nearest and saturated.
// The result sits in an output register: the next vector may stream in
// while the receiver stalls, but its own result holds until the previous
// one is taken. Reset clears all sums and drops any pending result.
module pearson_correlation_distance
    import pcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] x_sample, [31:16] y_sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] distance, [32:16] item_count, rest zero
    output logic             m_tuser    // [0] degenerate
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ACC    = 4'd1;
    localparam logic [3:0] ST_MSTART = 4'd2;
    localparam logic [3:0] ST_MWAIT  = 4'd3;
    localparam logic [3:0] ST_RSTART = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_DSTART = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    // product schedule
    localparam logic [2:0] MP_NXX = 3'd0;
    localparam logic [2:0] MP_XX  = 3'd1;
    localparam logic [2:0] MP_NYY = 3'd2;
    localparam logic [2:0] MP_YY  = 3'd3;
    localparam logic [2:0] MP_NXY = 3'd4;
    localparam logic [2:0] MP_XY  = 3'd5;
    localparam logic [2:0] MP_VV  = 3'd6;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  idx_reg;
    logic signed [SAMPLE_W-1:0] x_reg, y_reg;
    logic        last_reg;
    logic [OP_W-1:0] ta_reg, vx_reg, vy_reg, magc_reg;
    logic        neg_reg, degen_reg;

    logic        out_v_reg, out_degen_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    acc_ctl_t    acc_ctl;
    rd_ctl_t     rd_ctl;
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sx, sy;
    logic signed [SXY_W-1:0] sxy;
    logic [SQ_W-1:0]         sxx, syy;
    logic [SUM_W-1:0]        sx_mag, sy_mag;
    logic [SXY_W-1:0]        sxy_mag;

    logic              mul_start, mul_done, rd_done;
    logic [OP_W-1:0]   op_a, op_b;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic [64:0]       vdiff;
    logic [OP_W-1:0]   vclamp;
    logic [65:0]       sa, sb, cs, cmag;
    logic              take_out, s_fire;
    logic [DIST_W-1:0] dist_val;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign take_out = (state_reg == ST_FIN) && (!out_v_reg || m_tready);

    assign acc_ctl.acc_en = (state_reg == ST_ACC);
    assign acc_ctl.clear  = take_out;
    assign mul_start      = (state_reg == ST_MSTART);
    assign rd_ctl.sqrt_start = (state_reg == ST_RSTART);
    assign rd_ctl.div_start  = (state_reg == ST_DSTART);

    pcd_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .x_in    (x_reg),
        .y_in    (y_reg),
        .count   (n),
        .sum_x   (sx),
        .sum_y   (sy),
        .sum_xy  (sxy),
        .sum_xx  (sxx),
        .sum_yy  (syy)
    );

    assign sx_mag  = sx[SUM_W-1]  ? SUM_W'(0) - sx   : sx;
    assign sy_mag  = sy[SUM_W-1]  ? SUM_W'(0) - sy   : sy;
    assign sxy_mag = sxy[SXY_W-1] ? SXY_W'(0) - sxy  : sxy;

    always_comb begin
        case (idx_reg)
            MP_NXX: begin op_a = OP_W'(n);      op_b = OP_W'(sxx);     end
            MP_XX:  begin op_a = OP_W'(sx_mag); op_b = OP_W'(sx_mag);  end
            MP_NYY: begin op_a = OP_W'(n);      op_b = OP_W'(syy);     end
            MP_YY:  begin op_a = OP_W'(sy_mag); op_b = OP_W'(sy_mag);  end
            MP_NXY: begin op_a = OP_W'(n);      op_b = OP_W'(sxy_mag); end
            MP_XY:  begin op_a = OP_W'(sx_mag); op_b = OP_W'(sy_mag);  end
            MP_VV:  begin op_a = vx_reg;        op_b = vy_reg;         end
            default: begin op_a = '0;           op_b = '0;             end
        endcase
    end

    pcd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (prod),
        .done    (mul_done)
    );

    pcd_rootdiv u_rootdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rd_ctl),
        .radicand (prod),
        .cov_mag  (magc_reg),
        .quotient (q),
        .done     (rd_done)
    );

    // variance term n*S2 - S*S, clamped at zero
    assign vdiff  = {1'b0, ta_reg} - {1'b0, prod[OP_W-1:0]};
    assign vclamp = vdiff[64] ? '0 : vdiff[OP_W-1:0];

    // covariance term as sign and magnitude
    assign sa   = sxy[SXY_W-1] ? 66'd0 - {2'b00, ta_reg} : {2'b00, ta_reg};
    assign sb   = (sx[SUM_W-1] ^ sy[SUM_W-1]) ? 66'd0 - {2'b00, prod[OP_W-1:0]}
                                              : {2'b00, prod[OP_W-1:0]};
    assign cs   = sa - sb;
    assign cmag = cs[65] ? 66'd0 - cs : cs;

    assign dist_val = degen_reg ? '0
                    : neg_reg   ? ONE_Q14 + DIST_W'(q)
                    :             ONE_Q14 - DIST_W'(q);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_ACC;
            ST_ACC:    state_next = last_reg ? ST_MSTART : ST_IDLE;
            ST_MSTART: state_next = ST_MWAIT;
            ST_MWAIT: begin
                if (mul_done) begin
                    if (idx_reg == MP_VV)
                        state_next = ST_RSTART;
                    else if (idx_reg == MP_YY && (vx_reg == '0 || vclamp == '0))
                        state_next = ST_FIN;
                    else
                        state_next = ST_MSTART;
                end
            end
            ST_RSTART: state_next = ST_SQRT;
            ST_SQRT:   if (rd_done) state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    if (rd_done) state_next = ST_FIN;
            ST_FIN:    if (take_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (take_out)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg    <= s_tdata[SAMPLE_W-1:0];
            y_reg    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            last_reg <= s_tlast;
        end
        if (state_reg == ST_ACC) begin
            idx_reg   <= MP_NXX;
            degen_reg <= 1'b0;
        end
        if (state_reg == ST_MWAIT && mul_done) begin
            idx_reg <= idx_reg + 3'd1;
            case (idx_reg)
                MP_NXX, MP_NYY, MP_NXY: ta_reg <= prod[OP_W-1:0];
                MP_XX:  vx_reg <= vclamp;
                MP_YY: begin
                    vy_reg <= vclamp;
                    if (vx_reg == '0 || vclamp == '0)
                        degen_reg <= 1'b1;
                end
                MP_XY: begin
                    magc_reg <= cmag[OP_W-1:0];
                    neg_reg  <= cs[65];
                end
                default: ;
            endcase
        end
        if (take_out) begin
            out_dist_reg  <= dist_val;
            out_degen_reg <= degen_reg;
            out_cnt_reg   <= n;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_cnt_reg, out_dist_reg};
    assign m_tuser  = out_degen_reg;

endmodule
`default_nettype wire

// ===== design/pcd_checker.sv =====
`default_nettype none
module pcd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[15:0] == 16'd0)
        else $error("degenerate result with non-zero distance");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= 16'd32768)
        else $error("distance out of range");

    a_count_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32:16] != 17'd0)
        else $error("result with zero item count");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("pair taken while accumulating");

endmodule

bind pearson_correlation_distance pcd_checker u_pcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import pcd_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } pair_t;

    typedef struct packed {
        logic [15:0] distance;
        logic        degenerate;
        logic [16:0] item_count;
    } dist_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    pearson_correlation_distance uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    localparam int CYCLE_LIMIT = 2_000_000;

    pair_t        pending_pairs[$];
    dist_result_t expected_dists[$];

    // running sums of the predictor
    int unsigned  acc_count;
    longint       acc_sx, acc_sy, acc_sxy, acc_sxx, acc_syy;

    int           mismatches;
    int           pairs_sent;
    int           results_seen;
    int           degenerate_seen;
    longint       cycle_count;
    int           tx_gap;
    int           rx_stall;
    bit           quiet_phase;
    int           phase_len;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic logic [255:0] mag(input longint v);
        return (v < 0) ? 256'(-v) : 256'(v);
    endfunction

    function automatic logic [255:0] int_sqrt(input logic [255:0] p);
        logic [255:0] r;
        logic [255:0] c;
        r = '0;
        for (int b = 127; b >= 0; b--) begin
            c    = r;
            c[b] = 1'b1;
            if (c * c <= p) r = c;
        end
        return r;
    endfunction

    function automatic logic [255:0] var_term(input longint n, input longint sq,
                                              input longint s);
        logic [255:0] a;
        logic [255:0] b;
        a = 256'(n) * mag(sq);
        b = mag(s) * mag(s);
        return (a < b) ? '0 : a - b;
    endfunction

    // Accumulate one pair; on the last pair work out the distance and clear.
    task automatic accumulate_pair(input pair_t p);
        longint       x, y, n;
        logic [255:0] vx, vy, a, b, magc, s, num, den;
        bit           a_neg, b_neg, neg;
        logic [16:0]  q;
        dist_result_t r;
        x = longint'(p.x);
        y = longint'(p.y);
        if (acc_count < MAX_ITEMS) begin
            acc_count++;
            acc_sx  += x;
            acc_sy  += y;
            acc_sxy += x * y;
            acc_sxx += x * x;
            acc_syy += y * y;
        end
        if (!p.last) return;
        n            = acc_count;
        vx           = var_term(n, acc_sxx, acc_sx);
        vy           = var_term(n, acc_syy, acc_sy);
        r.item_count = 17'(n);
        if (vx == 0 || vy == 0) begin
            r.distance   = '0;
            r.degenerate = 1'b1;
        end else begin
            a     = 256'(n) * mag(acc_sxy);
            a_neg = acc_sxy < 0;
            b     = mag(acc_sx) * mag(acc_sy);
            b_neg = (acc_sx < 0) != (acc_sy < 0);
            if (a_neg == b_neg) begin
                if (a >= b) begin
                    magc = a - b;
                    neg  = a_neg;
                end else begin
                    magc = b - a;
                    neg  = !a_neg;
                end
            end else begin
                magc = a + b;
                neg  = a_neg;
            end
            s   = int_sqrt(vx * vy);
            // round half up: floor((32768*|C| + S) / (2*S))
            num = 256'd32768 * magc + s;
            den = s + s;
            q   = '0;
            for (int b2 = 15; b2 >= 0; b2--) begin
                if (256'(q | (17'd1 << b2)) * den <= num) q = q | (17'd1 << b2);
            end
            if (q > 17'd16384) q = 17'd16384;
            r.distance   = neg ? 16'(17'd16384 + q) : 16'(17'd16384 - q);
            r.degenerate = 1'b0;
        end
        expected_dists.push_back(r);
        acc_count = 0;
        acc_sx    = 0;
        acc_sy    = 0;
        acc_sxy   = 0;
        acc_sxx   = 0;
        acc_syy   = 0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_pair(input int x, input int y, input bit last);
        pair_t p;
        p.x    = 16'(x);
        p.y    = 16'(y);
        p.last = last;
        pending_pairs.push_back(p);
    endtask

    // Queue one vector of random content; style picks how x and y relate.
    task automatic push_vector(input int len);
        int style, x, y, cx, sc;
        style = $urandom_range(0, 9);
        cx    = $urandom_range(0, 65535) - 32768;
        sc    = $urandom_range(0, 15);
        for (int i = 0; i < len; i++) begin
            x = (style == 0) ? cx : int'($urandom_range(0, 65535)) - 32768;
            if (style >= 1 && style <= 3) x = x >>> sc;
            case (style)
                1, 4:    y = x + int'($urandom_range(0, 63)) - 32;
                2, 5:    y = -x + int'($urandom_range(0, 63)) - 32;
                3:       y = x;
                6:       y = cx;
                default: y = int'($urandom_range(0, 65535)) - 32768;
            endcase
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            push_pair(x, y, i == len - 1);
        end
    endtask

    // Drive the slave channel from the pending queue; predict on acceptance.
    always @(posedge aclk) begin
        pair_t p;
        bit    load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_pair(pair_t'({s_tdata[15:0], s_tdata[31:16], s_tlast}));
                pairs_sent++;
            end
            load = 1'b0;
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (pending_pairs.size() > 0) begin
                    p      = pending_pairs.pop_front();
                    load   = 1'b1;
                    tx_gap <= pick_gap();
                    s_tdata <= {p.y, p.x};
                    s_tlast <= p.last;
                end
                s_tvalid <= load;
            end
        end
    end

    // Stall the master channel at random and check each result transaction.
    always @(posedge aclk) begin
        dist_result_t e;
        if (!aresetn) begin
            m_tready    <= 1'b0;
            rx_stall    <= 0;
            quiet_phase <= 1'b0;
            phase_len   <= 300;
        end else begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("status: fail");
                $finish;
            end
            // alternate stretches with and without idling
            if (phase_len == 0) begin
                quiet_phase <= $urandom_range(0, 3) == 0;
                phase_len   <= $urandom_range(100, 1000);
            end else begin
                phase_len <= phase_len - 1;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser) degenerate_seen++;
                if (expected_dists.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: distance %0d count %0d degenerate %0b",
                                 m_tdata[15:0], m_tdata[32:16], m_tuser);
                end else begin
                    e = expected_dists.pop_front();
                    if (m_tdata[15:0] !== e.distance || m_tdata[32:16] !== e.item_count
                        || m_tuser !== e.degenerate) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected distance %0d count %0d degenerate ",
                                      "%0b, got %0d %0d %0b"},
                                     e.distance, e.item_count, e.degenerate,
                                     m_tdata[15:0], m_tdata[32:16], m_tuser);
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) < 3) begin
                rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int budget, len;
        aresetn         = 1'b0;
        mismatches      = 0;
        pairs_sent      = 0;
        results_seen    = 0;
        degenerate_seen = 0;
        cycle_count     = 0;
        acc_count       = 0;
        acc_sx          = 0;
        acc_sy          = 0;
        acc_sxy         = 0;
        acc_sxx         = 0;
        acc_syy         = 0;

        // single pair at the field extremes: zero variance
        push_pair(-32768, 32767, 1);
        // perfect correlation and perfect anti-correlation at full scale
        push_pair(32767, 32767, 0);
        push_pair(-32768, -32768, 1);
        push_pair(32767, -32768, 0);
        push_pair(-32768, 32767, 1);
        // constant x gives a zero variance term
        push_pair(5, 1, 0);
        push_pair(5, 2, 0);
        push_pair(5, 9, 1);
        // constant y, x at both extremes
        push_pair(-32768, -1, 0);
        push_pair(32767, -1, 1);
        // small mixed vector, weak correlation
        push_pair(0, 0, 0);
        push_pair(1, -1, 0);
        push_pair(-1, -1, 0);
        push_pair(100, 3, 0);
        push_pair(-7, 32767, 1);
        // orthogonal vector: distance exactly one
        push_pair(1, 1, 0);
        push_pair(-1, 1, 0);
        push_pair(1, -1, 0);
        push_pair(-1, -1, 1);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // random vectors, mostly short, a few longer
        budget = 1880;
        while (budget > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                              : $urandom_range(1, 40);
            if (len > budget) len = budget;
            push_vector(len);
            budget -= len;
        end

        wait (pending_pairs.size() == 0 && !s_tvalid);
        wait (expected_dists.size() == 0);
        repeat (300) @(posedge aclk);

        $display("%0d pairs sent, %0d distances checked (%0d degenerate), including extremes",
                 pairs_sent, results_seen, degenerate_seen);
        $display("and correlated, anti-correlated and constant vectors, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_dists.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
design/pcd_pkg.sv
design/pcd_accum.sv
design/pcd_mul.sv
design/pcd_rootdiv.sv
design/pearson_correlation_distance.sv
design/pcd_checker.sv
tb/sv/tb.sv
